>>> sv/timed_actuator_gait_sequencer_top_defines.svh
// Assertion macros shared by the gait sequencer modules
`ifndef TIMED_ACTUATOR_GAIT_SEQUENCER_TOP_DEFINES_SVH
`define TIMED_ACTUATOR_GAIT_SEQUENCER_TOP_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define TAGS_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// check a condition in the cycle after its trigger
`define TAGS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> sv/tags_pkg.sv
// Types, codes and helpers for the gait sequencer
package tags_pkg;

  localparam int CountW = 17;
  localparam int TimeW  = 16;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  localparam logic [1:0] CH_REAR  = 2'd0;
  localparam logic [1:0] CH_FRONT = 2'd1;
  localparam logic [1:0] CH_SPINE = 2'd2;

  localparam logic [1:0] REG_HEAT   = 2'd0;
  localparam logic [1:0] REG_COOL   = 2'd1;
  localparam logic [1:0] REG_SETTLE = 2'd2;

  localparam logic [TimeW-1:0] HeatReset   = 16'd500;
  localparam logic [TimeW-1:0] CoolReset   = 16'd1000;
  localparam logic [TimeW-1:0] SettleReset = 16'd200;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_REL1   = 8'b0000_0010,
    ST_CONTR  = 8'b0000_0100,
    ST_ATT1   = 8'b0000_1000,
    ST_REL2   = 8'b0001_0000,
    ST_EXT    = 8'b0010_0000,
    ST_ATT2   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] heat_time;
    logic [TimeW-1:0] cool_time;
    logic [TimeW-1:0] settle_time;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] cmd_channel;
    logic       cmd_heat;
    logic       all_release;
    logic       done_res;
    logic [2:0] phase_now;
  } res_t;

  function automatic logic [2:0] phase_of(input state_t s);
    logic [2:0] p;
    unique case (s)
      ST_IDLE:  p = 3'd0;
      ST_REL1:  p = 3'd1;
      ST_CONTR: p = 3'd2;
      ST_ATT1:  p = 3'd3;
      ST_REL2:  p = 3'd4;
      ST_EXT:   p = 3'd5;
      ST_ATT2:  p = 3'd6;
      ST_DONE:  p = 3'd7;
      default:  p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

>>> sv/tags_step.sv
// Phase state, elapsed count and per-item result logic of the gait sequencer
`include "timed_actuator_gait_sequencer_top_defines.svh"

module tags_step import tags_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic [1:0] mode,
  input  logic       dir,
  input  cfg_t       cfg,
  output res_t       res
);

  state_t              state, state_next;
  logic                forward_dir, forward_dir_next;
  logic [CountW-1:0]   count, count_next;
  logic [CountW-1:0]   count_inc;
  logic [CountW-1:0]   wait_long;
  logic [CountW-1:0]   heat_ext;
  logic                heat_done, long_done;
  logic [1:0]          pad_first, pad_second;

  assign count_inc  = (count == CountMax) ? count : count + 1'b1;
  assign wait_long  = {1'b0, cfg.settle_time} + {1'b0, cfg.cool_time};
  assign heat_ext   = {1'b0, cfg.heat_time};
  assign heat_done  = count_inc >= heat_ext;
  assign long_done  = count_inc >= wait_long;
  assign pad_first  = forward_dir ? CH_REAR : CH_FRONT;
  assign pad_second = forward_dir ? CH_FRONT : CH_REAR;

  always_comb begin
    state_next       = state;
    forward_dir_next = forward_dir;
    count_next       = count;
    res              = '0;
    unique case (mode)
      MODE_START: begin
        forward_dir_next = ~dir;
        state_next       = ST_REL1;
        count_next       = '0;
      end
      MODE_STOP: begin
        res.all_release  = 1'b1;
        state_next       = ST_IDLE;
        forward_dir_next = 1'b0;
        count_next       = '0;
      end
      MODE_TICK: begin
        count_next = count_inc;
        unique case (state)
          ST_IDLE: begin
            res.done_res = 1'b1;
          end
          ST_REL1: begin
            res.cmd_valid   = 1'b1;
            res.cmd_channel = pad_first;
            res.cmd_heat    = 1'b1;
            state_next      = ST_CONTR;
          end
          ST_CONTR: begin
            if (heat_done) begin
              res.cmd_valid   = 1'b1;
              res.cmd_channel = CH_SPINE;
              res.cmd_heat    = 1'b1;
              state_next      = ST_ATT1;
            end
          end
          ST_ATT1: begin
            if (heat_done) begin
              res.cmd_valid   = 1'b1;
              res.cmd_channel = pad_first;
              state_next      = ST_REL2;
            end
          end
          ST_REL2: begin
            if (long_done) begin
              res.cmd_valid   = 1'b1;
              res.cmd_channel = pad_second;
              res.cmd_heat    = 1'b1;
              state_next      = ST_EXT;
            end
          end
          ST_EXT: begin
            if (heat_done) begin
              res.cmd_valid   = 1'b1;
              res.cmd_channel = CH_SPINE;
              state_next      = ST_ATT2;
            end
          end
          ST_ATT2: begin
            if (heat_done) begin
              res.cmd_valid   = 1'b1;
              res.cmd_channel = pad_second;
              state_next      = ST_DONE;
            end
          end
          ST_DONE: begin
            if (long_done) begin
              res.done_res = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          default: begin
            state_next = state;
          end
        endcase
        if (state_next != state) begin
          count_next = '0;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
    res.phase_now = phase_of(state_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      forward_dir <= 1'b0;
      count       <= '0;
    end else if (step_en) begin
      state       <= state_next;
      forward_dir <= forward_dir_next;
      count       <= count_next;
    end
  end

  `TAGS_ASSERT_NEXT(a_stop_idle, clk, rst, step_en && mode == MODE_STOP,
    state == ST_IDLE && count == '0 && !forward_dir, "stop did not return to idle")
  `TAGS_ASSERT_NEXT(a_start_rel1, clk, rst, step_en && mode == MODE_START,
    state == ST_REL1 && count == '0, "start did not enter the first phase")
  `TAGS_ASSERT_NOW(a_cmd_tick_only, clk, rst, res.cmd_valid,
    mode == MODE_TICK && state != ST_IDLE && state != ST_DONE,
    "command outside an active tick")

endmodule

>>> sv/timed_actuator_gait_sequencer_top.sv
// Top level of the gait sequencer: register port, item handshake and result register
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------------
//  config  | psel/penable/...  | paddr[3:0], pwdata[31:0], prdata[31:0]
//  input   | in_valid/in_ready | mode[1:0], dir
//  output  | out_valid/out_rdy | cmd_valid, cmd_channel, cmd_heat, all_release,
//          |                   | done_res, phase_now
//
// One item per cycle while the output is not stalled; each result appears in the cycle after its item is taken.
// The result register is the only stage: an item is taken whenever it is empty
// or being drained in the same cycle, so a stall holds one result and blocks input.
// Synchronous reset returns the sequencer to idle and loads the default times.
`include "timed_actuator_gait_sequencer_top_defines.svh"

module timed_actuator_gait_sequencer_top import tags_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic        dir,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        cmd_valid,
  output logic [1:0]  cmd_channel,
  output logic        cmd_heat,
  output logic        all_release,
  output logic        done_res,
  output logic [2:0]  phase_now
);

  cfg_t       cfg;
  res_t       res, res_q;
  logic       step_en;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heat_time   <= HeatReset;
      cfg.cool_time   <= CoolReset;
      cfg.settle_time <= SettleReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HEAT:   cfg.heat_time   <= pwdata[TimeW-1:0];
        REG_COOL:   cfg.cool_time   <= pwdata[TimeW-1:0];
        REG_SETTLE: cfg.settle_time <= pwdata[TimeW-1:0];
        default:    cfg.heat_time   <= cfg.heat_time;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEAT:   prdata = {16'd0, cfg.heat_time};
      REG_COOL:   prdata = {16'd0, cfg.cool_time};
      REG_SETTLE: prdata = {16'd0, cfg.settle_time};
      default:    prdata = '0;
    endcase
  end

  assign in_ready = !out_valid || out_ready;
  assign step_en  = in_valid && in_ready;

  tags_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .mode    (mode),
    .dir     (dir),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_q <= res;
    end
  end

  assign cmd_valid   = res_q.cmd_valid;
  assign cmd_channel = res_q.cmd_channel;
  assign cmd_heat    = res_q.cmd_heat;
  assign all_release = res_q.all_release;
  assign done_res    = res_q.done_res;
  assign phase_now   = res_q.phase_now;

  `TAGS_ASSERT_NOW(a_cmd_not_stop, clk, rst, out_valid && cmd_valid,
    !all_release && !done_res, "command mixed with stop or done")
  `TAGS_ASSERT_NOW(a_done_idle, clk, rst, out_valid && (done_res || all_release),
    phase_now == 3'd0, "done or stop not at idle")
  `TAGS_ASSERT_NEXT(a_take_loads, clk, rst, step_en, out_valid,
    "taken item produced no result")

endmodule
